// ----- sv/exchange_sort_buffer_assert.svh -----
// assertion macros for the exchange sort buffer
`ifndef EXCHANGE_SORT_BUFFER_ASSERT_SVH
`define EXCHANGE_SORT_BUFFER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ESB_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ESB_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- sv/esb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package esb_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CUR,
        ST_SORT_CMP,
        ST_SORT_WB,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    function automatic logic sgt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

`default_nettype wire

// ----- sv/esb_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esb_mem
    import esb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire t_mem_ctl                 i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/esb_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module esb_seq
    import esb_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [DATA_W-1:0]            i_s_axis_tdata,
    input  wire logic                         i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [DATA_W-1:0]            o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    output logic                              o_m_axis_tuser,
    output t_mem_ctl                          o_mem_ctl,
    output logic      [$clog2(MAX_ITEMS)-1:0] o_waddr,
    output logic      [DATA_W-1:0]            o_wdata,
    output logic      [$clog2(MAX_ITEMS)-1:0] o_raddr,
    input  wire logic [DATA_W-1:0]            i_rdata
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ITEMS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [CW-1:0]     r_k, n_k;
    logic [DATA_W-1:0] r_cur, n_cur;

    logic [CW-1:0]     w_fill_nx;
    logic [CW-1:0]     w_i_nx;
    logic [CW-1:0]     w_i_nx2;
    logic [CW-1:0]     w_j_nx;
    logic [CW-1:0]     w_k_nx;

    assign w_fill_nx = r_fill + CW'(1);
    assign w_i_nx    = r_i + CW'(1);
    assign w_i_nx2   = r_i + CW'(2);
    assign w_j_nx    = r_j + CW'(1);
    assign w_k_nx    = r_k + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    always_comb begin
        n_state         = r_state;
        n_fill          = r_fill;
        n_ovf           = r_ovf;
        n_i             = r_i;
        n_j             = r_j;
        n_k             = r_k;
        n_cur           = r_cur;
        o_mem_ctl       = '0;
        o_waddr         = '0;
        o_wdata         = '0;
        o_raddr         = '0;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    if (r_fill < FULL_CNT) begin
                        o_mem_ctl.we = 1'b1;
                        o_waddr      = r_fill[AW-1:0];
                        o_wdata      = i_s_axis_tdata;
                        n_fill       = w_fill_nx;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_i = '0;
                        n_k = '0;
                        // a single word needs no sorting
                        if (n_fill == CW'(1)) begin
                            n_state = ST_EMIT_RD;
                        end else begin
                            n_state = ST_SORT_RD;
                        end
                    end
                end
            end
            ST_SORT_RD: begin
                o_mem_ctl.re = 1'b1;
                o_raddr      = r_i[AW-1:0];
                n_state      = ST_SORT_CUR;
            end
            ST_SORT_CUR: begin
                n_cur        = i_rdata;
                o_mem_ctl.re = 1'b1;
                o_raddr      = w_i_nx[AW-1:0];
                n_j          = w_i_nx;
                n_state      = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                // held word at position i swaps with a smaller later word
                if (sgt(r_cur, i_rdata)) begin
                    o_mem_ctl.we = 1'b1;
                    o_waddr      = r_j[AW-1:0];
                    o_wdata      = r_cur;
                    n_cur        = i_rdata;
                end
                if (w_j_nx < r_fill) begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = w_j_nx[AW-1:0];
                    n_j          = w_j_nx;
                end else begin
                    n_state = ST_SORT_WB;
                end
            end
            ST_SORT_WB: begin
                o_mem_ctl.we = 1'b1;
                o_waddr      = r_i[AW-1:0];
                o_wdata      = r_cur;
                n_i          = w_i_nx;
                if (w_i_nx2 < r_fill) begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = w_i_nx[AW-1:0];
                    n_state      = ST_SORT_CUR;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                o_mem_ctl.re = 1'b1;
                o_raddr      = r_k[AW-1:0];
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready) begin
                    if (w_k_nx == r_fill) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        o_raddr      = w_k_nx[AW-1:0];
                        n_k          = w_k_nx;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_m_axis_tdata = i_rdata;
    assign o_m_axis_tlast = (w_k_nx == r_fill);
    assign o_m_axis_tuser = o_m_axis_tlast & r_ovf;

endmodule

`default_nettype wire

// ----- sv/exchange_sort_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// exchange sort buffer: signed 32-bit words stream in one per cycle and are stored in a
// single memory of MAX_ITEMS entries; words past that size are dropped. the word marked
// tlast closes the set, after which the input is held off while the set is sorted in place
// in ascending order and then streamed out, tlast on the final word and tuser on it when
// any word of the set was dropped. sorting compares one pair per cycle through the
// memory's single read port and single write port; a set of one word skips the sort.
// the output then runs at one word per cycle while the receiver holds tready, after a
// first read from the memory. the input accepts no word while the sort or the output runs.

`include "exchange_sort_buffer_assert.svh"

module exchange_sort_buffer
    import esb_pkg::*;
#(
    parameter int MAX_ITEMS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [DATA_W-1:0] i_s_axis_tdata,   // value
    input  wire logic              i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic      [DATA_W-1:0] o_m_axis_tdata,   // sorted_value
    output logic                   o_m_axis_tlast,
    output logic                   o_m_axis_tuser    // dropped
);

    localparam int AW = $clog2(MAX_ITEMS);

    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_rdata;

    esb_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_mem_ctl       (w_mem_ctl),
        .o_waddr         (w_waddr),
        .o_wdata         (w_wdata),
        .o_raddr         (w_raddr),
        .i_rdata         (w_rdata)
    );

    esb_mem #(
        .DEPTH (MAX_ITEMS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `ESB_ASSERT_IMP(a_out_blocks_in, o_m_axis_tvalid, !o_s_axis_tready,
                    "input open during output")
    `ESB_ASSERT_NXT(a_last_reopens, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast,
                    o_s_axis_tready, "input not reopened after last word")
    `ESB_ASSERT_IMP(a_no_rw_hit, w_mem_ctl.we && w_mem_ctl.re, w_waddr != w_raddr,
                    "read and write hit the same entry")
    `ESB_ASSERT_IMP(a_drop_on_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast,
                    "drop flag off the last word")

endmodule

`default_nettype wire

// ----- verif/exchange_sort_buffer_test.sv -----
`timescale 1ns / 1ps

module exchange_sort_buffer_test;
    import esb_pkg::*;

    localparam int SET_CAP = 16;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              barrier;
    } feed_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              dropped;
    } sorted_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata = '0;   // value
    logic              s_tlast = 1'b0;
    logic              m_tready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [DATA_W-1:0] o_m_axis_tdata; // sorted_value
    logic              o_m_axis_tlast;
    logic              o_m_axis_tuser; // dropped

    feed_t             feed_q[$];
    sorted_t           sorted_due[$];
    logic [DATA_W-1:0] held_words[SET_CAP];
    int                held_count = 0;
    logic              spilled = 1'b0;
    int                mismatches = 0;

    int                send_gap = 0;
    bit                send_steady = 1'b0;
    int                recv_gap = 0;
    int                recv_hold = 0;
    bit                recv_steady = 1'b0;
    int                words_taken = 0;

    exchange_sort_buffer #(
        .MAX_ITEMS(SET_CAP)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    // stores one accepted word and, on the closing word, queues the set in sorted order
    function automatic void absorb_word(input logic [DATA_W-1:0] value, input logic last);
        logic [DATA_W-1:0] ordered[SET_CAP];
        logic [DATA_W-1:0] swap;
        sorted_t           word;
        if (held_count < SET_CAP) begin
            held_words[held_count] = value;
            held_count++;
        end else begin
            spilled = 1'b1;
        end
        if (last) begin
            ordered = held_words;
            for (int i = 0; i + 1 < held_count; i++) begin
                for (int j = i + 1; j < held_count; j++) begin
                    if ($signed(ordered[i]) > $signed(ordered[j])) begin
                        swap = ordered[i];
                        ordered[i] = ordered[j];
                        ordered[j] = swap;
                    end
                end
            end
            for (int k = 0; k < held_count; k++) begin
                word.value = ordered[k];
                word.last = (k == held_count - 1);
                word.dropped = word.last && spilled;
                sorted_due.push_back(word);
            end
            held_count = 0;
            spilled = 1'b0;
        end
    endfunction

    function automatic void queue_word(input logic [DATA_W-1:0] value, input logic last);
        feed_t item;
        item.value = value;
        item.last = last;
        item.barrier = 1'b0;
        feed_q.push_back(item);
    endfunction

    function automatic void queue_barrier();
        feed_t item;
        item = '0;
        item.barrier = 1'b1;
        feed_q.push_back(item);
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                3: return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end else if (mode <= 2) begin
            return DATA_W'($signed($urandom_range(0, 8)) - 4);
        end
        return $urandom;
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic  nxt_valid;
        feed_t item;
        nxt_valid = s_tvalid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (feed_q.size() > 0) begin
                    if (feed_q[0].barrier) begin
                        if (!s_tvalid && sorted_due.size() == 0) begin
                            item = feed_q.pop_front();
                        end
                    end else begin
                        item = feed_q.pop_front();
                        s_tdata <= item.value;
                        s_tlast <= item.last;
                        nxt_valid = 1'b1;
                        if ($urandom_range(0, 39) == 0) begin
                            send_steady = !send_steady;
                        end
                        send_gap = send_steady ? 0 : $urandom_range(0, 3);
                    end
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                words_taken++;
                if ($urandom_range(0, 39) == 0) begin
                    recv_steady = !recv_steady;
                end
                if (words_taken == 20 || words_taken == 150) begin
                    recv_hold = 300;
                end else begin
                    recv_gap = recv_steady ? 0 : $urandom_range(0, 3);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        sorted_t want;
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                absorb_word(s_tdata, s_tlast);
            end
            if (o_m_axis_tvalid && m_tready) begin
                if (sorted_due.size() == 0) begin
                    flag_mismatch("unexpected word", o_m_axis_tdata, '0);
                end else begin
                    want = sorted_due.pop_front();
                    if (o_m_axis_tdata !== want.value) begin
                        flag_mismatch("sorted value", o_m_axis_tdata, want.value);
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        flag_mismatch("tlast", DATA_W'(o_m_axis_tlast), DATA_W'(want.last));
                    end
                    if (o_m_axis_tuser !== want.dropped) begin
                        flag_mismatch("dropped flag", DATA_W'(o_m_axis_tuser),
                                      DATA_W'(want.dropped));
                    end
                end
            end
        end
    end

    initial begin
        int fed;
        int set_len;
        int pick;

        // single word set
        queue_word(32'h7fff_ffff, 1'b1);
        // extremes out of order
        queue_word(32'h7fff_ffff, 1'b0);
        queue_word(32'h8000_0000, 1'b0);
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hffff_ffff, 1'b0);
        queue_word(32'h0000_0001, 1'b1);
        queue_barrier();
        // equal values
        queue_word(32'd7, 1'b0);
        queue_word(32'hffff_fffd, 1'b0);
        queue_word(32'd7, 1'b1);
        // overflow, closing word itself dropped
        for (int k = 0; k < SET_CAP + 1; k++) begin
            queue_word(DATA_W'(SET_CAP - k) ^ {DATA_W{k[0]}}, k == SET_CAP);
        end
        queue_barrier();

        fed = 0;
        while (fed < 370) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                set_len = SET_CAP;
            end else if (pick == 1) begin
                set_len = $urandom_range(SET_CAP + 1, SET_CAP + 4);
            end else if (pick == 2) begin
                set_len = 1;
            end else begin
                set_len = $urandom_range(2, SET_CAP - 1);
            end
            for (int k = 0; k < set_len; k++) begin
                queue_word(draw_value(), k == set_len - 1);
            end
            fed += set_len;
            if ($urandom_range(0, 9) == 0) begin
                queue_barrier();
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || s_tvalid) begin
            @(posedge i_clk);
        end
        while (sorted_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (sorted_due.size() != 0) begin
            flag_mismatch("missing words", '0, DATA_W'(sorted_due.size()));
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
